>>> rtl/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants of the weighted roulette sampler
// Request and result structs, register indexes, status codes and the
// fixed field widths.
// ----------------------------------------------------------------------------
package wrs_pkg;

  // fixed field widths
  localparam int SLOT_W   = 6;
  localparam int WEIGHT_W = 17;
  localparam int FRAC_W   = 16;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  // fraction bits of the random value (the shift of the target product)
  localparam int FRACTION_BITS = 16;

  // weight count holds at most 127 entries of 17 bits
  localparam int SUM_W  = WEIGHT_W + CFG_W;
  localparam int PROD_W = SUM_W + FRAC_W;

  // 1.0 in Q1.16
  localparam logic [SUM_W-1:0] WEIGHT_ONE = SUM_W'(65536);

  // request codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE    = 1'b1;

  // sample modes
  localparam logic MODE_SCALE      = 1'b0;
  localparam logic MODE_NORMALIZED = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_ONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic                func;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
    logic [FRAC_W-1:0]   rand_fraction;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    chosen_index;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

>>> rtl/wrs_ram.sv
// ----------------------------------------------------------------------------
// wrs_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wrs_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/weighted_roulette_sampler_top.sv
// ----------------------------------------------------------------------------
// weighted_roulette_sampler_top: roulette-wheel selection over stored weights
// A request either loads a Q1.16 weight into a slot or draws one sample.
//
// Usage:
//   A request is taken on a clock edge with start high and busy low.
//   A load request writes the weight memory in that cycle and gives no
//   result; busy stays low, so another request may follow at once.
//   A sample request raises busy. The block reads the first weights_in_use
//   entries (at most MAX_WEIGHTS) once to sum them, multiplies the sum by
//   the random fraction, then reads the entries again, subtracting each
//   weight from the target until one exceeds it. In normalized mode a sum
//   other than one ends the sample with status not-one instead. The result
//   appears on rsp_o for one cycle with done_o high, in the cycle that busy
//   falls; the receiver cannot stall. Both passes stream one memory read per
//   cycle through the single read port; that port sets the rate.
//   Configuration writes are taken any cycle; write them while idle. Reset
//   clears the registers (weights_in_use 1, sample_mode 0) and the control
//   state; weight memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
module weighted_roulette_sampler_top #(
  parameter int MAX_WEIGHTS = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  wrs_pkg::req_t                          req_i,
  output logic                                   done_o,
  output wrs_pkg::rsp_t                          rsp_o,
  input  logic                                   cfg_we_i,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [wrs_pkg::CFG_W-1:0]              cfg_data_i
);

  import wrs_pkg::*;

  localparam int AW = $clog2(MAX_WEIGHTS);
  localparam int CW = $clog2(MAX_WEIGHTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_SRCH
  } state_e;

  state_e                state_q;
  logic                  done_q;
  rsp_t                  rsp_q;
  logic [CW-1:0]         idx_q;
  logic                  rd_vld_q;
  logic [AW-1:0]         didx_q;

  logic [CFG_W-1:0]      wiu_q;
  logic                  mode_q;

  logic [CW-1:0]         n_q;
  logic [FRAC_W-1:0]     frac_q;
  logic [SUM_W-1:0]      sum_q;
  logic [SUM_W-1:0]      target_q;

  logic                  accept;
  logic                  load_we;
  logic                  sample_go;
  logic [CW-1:0]         n_eff;
  logic                  issue;
  logic [WEIGHT_W-1:0]   rdata;
  logic [SUM_W-1:0]      rdata_ext;
  logic                  hit;
  logic                  sum_fail;
  logic [PROD_W-1:0]     prod;

  // request handshake
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign load_we   = accept && (req_i.func == FUNC_LOAD) &&
                     (32'(req_i.slot) < MAX_WEIGHTS);
  assign sample_go = accept && (req_i.func == FUNC_SAMPLE);

  // entry count, saturated to the memory depth
  assign n_eff = (32'(wiu_q) > MAX_WEIGHTS) ? CW'(MAX_WEIGHTS) : CW'(32'(wiu_q));

  // read stream: one address per cycle while entries remain
  assign issue     = ((state_q == ST_SUM) || (state_q == ST_SRCH)) && (idx_q < n_q);
  assign rdata_ext = SUM_W'(rdata);
  assign hit       = rd_vld_q && (target_q < rdata_ext);

  // multiply step
  assign sum_fail = (mode_q == MODE_NORMALIZED) && (sum_q != WEIGHT_ONE);
  assign prod     = PROD_W'(sum_q) * PROD_W'(frac_q);

  // weight memory
  wrs_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_WEIGHTS)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(req_i.slot)),
    .wdata_i (req_i.weight),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiu_q  <= CFG_W'(1);
      mode_q <= MODE_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WEIGHTS_IN_USE: wiu_q  <= cfg_data_i;
        CFG_SAMPLE_MODE:    mode_q <= cfg_data_i[0];
        default:            ;
      endcase
    end
  end

  // sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      done_q   <= 1'b0;
      rsp_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      rd_vld_q <= issue;
      if (issue) begin
        idx_q <= idx_q + CW'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (sample_go) begin
            idx_q    <= '0;
            rd_vld_q <= 1'b0;
            state_q  <= ST_SUM;
          end
        end
        ST_SUM: begin
          // done once nothing is issued and nothing is in flight
          if (!issue && !rd_vld_q) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          idx_q    <= '0;
          rd_vld_q <= 1'b0;
          if (sum_fail) begin
            rsp_q   <= '{chosen_index: '0, status: ST_NOT_ONE};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (hit) begin
            rsp_q   <= '{chosen_index: IDX_W'(didx_q), status: ST_OK};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (!issue && !rd_vld_q) begin
            rsp_q   <= '{chosen_index: '0, status: ST_NOT_FOUND};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    didx_q <= idx_q[AW-1:0];
    if (sample_go) begin
      n_q    <= n_eff;
      frac_q <= req_i.rand_fraction;
      sum_q  <= '0;
    end else if (state_q == ST_SUM && rd_vld_q) begin
      sum_q <= sum_q + rdata_ext;
    end
    if (state_q == ST_MUL) begin
      target_q <= prod[FRACTION_BITS +: SUM_W];
    end else if (state_q == ST_SRCH && rd_vld_q && !hit) begin
      target_q <= target_q - rdata_ext;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef ASSERT_OFF
  // a result ends a busy sample
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result without a preceding sample");

  // failed results carry index zero
  a_fail_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> rsp_o.chosen_index == '0)
    else $error("nonzero index on failed sample");

  // the read stream never runs past the entries in use
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM || state_q == ST_SRCH) |-> idx_q <= n_q)
    else $error("read index beyond entry count");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the weighted roulette sampler
// A driver pours load and sample requests from a pending queue. A predictor
// tracks the weight store and the registers and works out each sample's
// pick. A monitor compares every done_o result with the oldest predicted
// pick. The run steps through several register settings, the extremes
// among them, with and without sender idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wrs_pkg::*;

  localparam int MAX_SLOTS    = 64;
  localparam int SETTLE_PAD   = 150;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 80;
  localparam int RAND_PHASES  = 12;

  // dut ports
  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  req_t          req_i = '0;
  logic          done_o;
  rsp_t          rsp_o;
  logic          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // requests waiting to be driven and picks waiting to come out
  req_t          pending[$];
  rsp_t          pick_q[$];

  // predictor state
  logic [WEIGHT_W-1:0] weight_mirror[MAX_SLOTS];
  logic [CFG_W-1:0]    count_mirror = CFG_W'(1);
  logic                mode_mirror = MODE_SCALE;

  int unsigned   idle_pct = 0;
  int unsigned   queued = 0;
  int unsigned   accepted = 0;
  int unsigned   picks_checked = 0;
  int unsigned   settings_used = 1;
  int unsigned   fail_count = 0;
  int unsigned   stall_cycles = 0;

  logic          req_fire;
  assign req_fire = start && !busy;

  weighted_roulette_sampler_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // roulette pick over the mirrored store
  function automatic rsp_t predict_pick(logic [FRAC_W-1:0] frac);
    int unsigned       n;
    longint unsigned   total;
    longint unsigned   target;
    rsp_t              r;
    n = (count_mirror > MAX_SLOTS) ? MAX_SLOTS : count_mirror;
    total = 0;
    r.chosen_index = '0;
    r.status = ST_NOT_FOUND;
    for (int i = 0; i < n; i++) total += weight_mirror[i];
    // normalized mode demands a sum of exactly one
    if (mode_mirror == MODE_NORMALIZED && total != 65536) begin
      r.status = ST_NOT_ONE;
      return r;
    end
    target = (total * 64'(frac)) >> FRACTION_BITS;
    for (int i = 0; i < n; i++) begin
      if (target < weight_mirror[i]) begin
        r.chosen_index = IDX_W'(i);
        r.status = ST_OK;
        return r;
      end
      target -= weight_mirror[i];
    end
    return r;
  endfunction

  task automatic report_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // driver: accept, update the predictor, present the next request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WEIGHTS_IN_USE) count_mirror <= cfg_data_i;
        else mode_mirror <= cfg_data_i[0];
      end
      if (req_fire) begin
        accepted++;
        if (req_i.func == FUNC_LOAD) weight_mirror[req_i.slot] <= req_i.weight;
        else pick_q.push_back(predict_pick(req_i.rand_fraction));
      end
      if (!start || req_fire) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          req_i <= pending.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result against the oldest pick, plus watchdog
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pick_q.size() == 0) begin
          report_fail($sformatf("result idx=%0d st=%0d with nothing expected",
                                rsp_o.chosen_index, rsp_o.status));
        end else begin
          want = pick_q.pop_front();
          picks_checked++;
          if (rsp_o.chosen_index !== want.chosen_index || rsp_o.status !== want.status)
            report_fail($sformatf("pick idx=%0d st=%0d, expected idx=%0d st=%0d",
                                  rsp_o.chosen_index, rsp_o.status,
                                  want.chosen_index, want.status));
        end
      end
      if (req_fire || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // request builders
  task automatic push_load(int unsigned slot, int unsigned w);
    req_t r;
    r.func = FUNC_LOAD;
    r.slot = SLOT_W'(slot);
    r.weight = WEIGHT_W'(w);
    r.rand_fraction = FRAC_W'($urandom);
    pending.push_back(r);
    queued++;
  endtask

  task automatic push_sample(int unsigned frac);
    req_t r;
    r.func = FUNC_SAMPLE;
    r.slot = SLOT_W'($urandom);
    r.weight = WEIGHT_W'($urandom);
    r.rand_fraction = FRAC_W'(frac);
    pending.push_back(r);
    queued++;
  endtask

  function automatic int unsigned pick_weight();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65536;
      2: return 'h1FFFF;
      3: return $urandom_range(0, 'h1FFFF);
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  function automatic int unsigned pick_frac();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 'hFFFF;
      default: return $urandom_range(0, 'hFFFF);
    endcase
  endfunction

  // wait until nothing is queued or in flight, then let the block go idle
  task automatic settle();
    @(negedge clk_i);
    while (pending.size() != 0 || start || pick_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_PAD) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int unsigned cnt, logic mode);
    settle();
    write_reg(CFG_WEIGHTS_IN_USE, CFG_W'(cnt));
    // upper data bits of the mode register are don't-care
    write_reg(CFG_SAMPLE_MODE, {6'($urandom), mode});
    settings_used++;
    @(negedge clk_i);
  endtask

  // load the first n entries so that they sum to exactly one
  task automatic load_unit_sum(int unsigned n);
    int unsigned left;
    int unsigned w;
    int unsigned hot;
    left = 65536;
    // sometimes all the mass sits on one entry
    if ($urandom_range(0, 3) == 0) begin
      hot = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) push_load(i, (i == hot) ? 65536 : 0);
    end else begin
      for (int i = 0; i < n - 1; i++) begin
        w = $urandom_range(0, 2 * left / (n - i) + 1);
        if (w > left) w = left;
        push_load(i, w);
        left -= w;
      end
      push_load(n - 1, left);
    end
  endtask

  // random mix for the current setting
  task automatic random_mix(int unsigned cnt, logic mode, int unsigned items);
    int unsigned n_use;
    int unsigned stop_at;
    n_use = (cnt > MAX_SLOTS) ? MAX_SLOTS : cnt;
    stop_at = queued + items;
    while (queued < stop_at) begin
      if (mode == MODE_NORMALIZED) begin
        if ($urandom_range(0, 9) < 7) begin
          load_unit_sum(n_use);
          repeat ($urandom_range(2, 12)) push_sample(pick_frac());
        end else begin
          // broken distribution
          push_load($urandom_range(0, n_use - 1), pick_weight());
          push_sample(pick_frac());
        end
      end else begin
        if ($urandom_range(0, 9) < 3) begin
          if ($urandom_range(0, 3) == 0) push_load($urandom_range(0, 63), pick_weight());
          else push_load($urandom_range(0, n_use - 1), pick_weight());
        end else begin
          push_sample(pick_frac());
        end
      end
    end
  endtask

  // stimulus sequence
  initial begin
    int unsigned rnd_cnt[RAND_PHASES];
    logic        rnd_mode[RAND_PHASES];
    int unsigned idle_set[3];
    rnd_cnt  = '{2, 64, 5, 127, 17, 64, 1, 33, 100, 9, 48, 64};
    rnd_mode = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    idle_set = '{0, 56, 19};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every entry written before any sample reads it
    for (int s = 0; s < MAX_SLOTS; s++) push_load(s, pick_weight());

    // reset setting: one entry, scale mode
    push_load(0, 0);
    push_sample('h1234);
    push_load(0, 65536);
    push_sample(0);
    push_sample('hFFFF);
    push_load(0, 'h1FFFF);
    push_sample('hFFFF);

    // all weights zero, then one tiny weight
    set_config(3, MODE_SCALE);
    push_load(0, 0);
    push_load(1, 0);
    push_load(2, 0);
    push_sample('hFFFF);
    push_load(1, 1);
    push_sample(0);
    push_sample('hFFFF);

    // zero count in both modes
    set_config(0, MODE_SCALE);
    push_sample('h8000);
    set_config(0, MODE_NORMALIZED);
    push_sample('h8000);

    // exact half and half distribution, then one step off
    set_config(2, MODE_NORMALIZED);
    push_load(0, 32768);
    push_load(1, 32768);
    push_sample('h7FFF);
    push_sample('h8000);
    push_load(1, 32769);
    push_sample('h4000);

    // count beyond the store saturates
    set_config(127, MODE_SCALE);
    push_sample('hFFFF);
    push_sample(0);

    // random phases
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_config(rnd_cnt[p], rnd_mode[p]);
      idle_pct = idle_set[p % 3];
      random_mix(rnd_cnt[p], rnd_mode[p], PHASE_ITEMS);
    end

    settle();
    if (pick_q.size() != 0) report_fail($sformatf("%0d picks never came", pick_q.size()));
    $display("run: %0d requests accepted, %0d picks checked, %0d register settings",
             accepted, picks_checked, settings_used);
    $display("covered zero and saturated counts, both modes, idle and busy senders");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
